### sv/lu_full_pivot_decomposer_assert.svh
// Assertion macros shared by the decomposer RTL.
`ifndef LU_FULL_PIVOT_DECOMPOSER_ASSERT_SVH
`define LU_FULL_PIVOT_DECOMPOSER_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define LUFP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lufp assertion failed");

// Next-cycle implication.
`define LUFP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lufp assertion failed");

`endif

### sv/lufp_pkg.sv
package lufp_pkg;

    localparam int MATRIX_SIZE_DEF = 4;
    localparam int DATA_WIDTH_DEF  = 32;
    localparam int FRAC_BITS       = 16;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_S_RD,
        ST_S_CMP,
        ST_SWAP,
        ST_P_RD,
        ST_P_CAP,
        ST_N_RD,
        ST_N_CAP,
        ST_DIV,
        ST_X_RD,
        ST_X_CAP,
        ST_A_RD,
        ST_A_CAP,
        ST_MUL,
        ST_UPD,
        ST_O_RD,
        ST_O_CAP,
        ST_O_WAIT
    } lufp_state_t;

    typedef struct packed {
        logic in_ready;
        logic srch_first;
        logic srch_cmp;
        logic swap;
        logic piv_cap;
        logic num_cap;
        logic lm_wr;
        logic x_cap;
        logic a_cap;
        logic mul;
        logic upd_wr;
        logic out_load;
        logic clear;
    } lufp_cmd_t;

    typedef struct packed {
        logic load_last;
        logic div_done;
        logic out_taken;
    } lufp_status_t;

endpackage

### sv/lufp_ram.sv
module lufp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/lufp_div.sv
// Restoring divider, one quotient bit per cycle: quo = (num << FRAC_BITS) / den.
module lufp_div import lufp_pkg::*; #(
    parameter int DW = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [DW-1:0]           num,
    input  logic [DW-1:0]           den,
    output logic                    done,
    output logic [DW+FRAC_BITS-1:0] quo
);

    localparam int QW = DW + FRAC_BITS;
    localparam int CW = $clog2(QW + 1);

    logic [QW-1:0] sh_reg, sh_next;
    logic [QW-1:0] q_reg, q_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    assign trial = {rem_reg, sh_reg[QW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        sh_next   = sh_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            sh_next   = QW'(num) << FRAC_BITS;
            q_next    = '0;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CW'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            sh_next  = sh_reg << 1;
            q_next   = {q_reg[QW-2:0], ge};
            rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

### sv/lufp_dp.sv
// Datapath: matrix and multiplier stores, permutations, pivot search,
// divider, multiply and saturating update, result register.
// The work store is addressed through a row and a column map that follow every
// pivot swap and survive between runs, so its contents always sit in the
// permuted order; a short load then rewrites the permuted matrix in place.
module lufp_dp import lufp_pkg::*; #(
    parameter int N  = MATRIX_SIZE_DEF,
    parameter int DW = DATA_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lufp_cmd_t            cmd,
    output lufp_status_t         st,
    input  logic [$clog2(N)-1:0] row,
    input  logic [$clog2(N)-1:0] col,
    input  logic [$clog2(N)-1:0] k,
    input  logic                 in_valid,
    input  logic [DW-1:0]        in_data,
    input  logic                 in_last,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [$clog2(N)-1:0] out_row,
    output logic [$clog2(N)-1:0] out_col,
    output logic [DW-1:0]        out_lower,
    output logic [DW-1:0]        out_upper,
    output logic [$clog2(N)-1:0] out_row_perm,
    output logic [$clog2(N)-1:0] out_col_perm,
    output logic                 out_singular,
    output logic                 out_last
);

    localparam int IW    = $clog2(N);
    localparam int CELLS = N * N;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int QW    = DW + FRAC_BITS;
    localparam int PW    = 2 * DW;
    localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] ONE  =
        (FRAC_BITS < DW - 1) ? (DW'(1) << FRAC_BITS) : MAXV;
    localparam logic [QW-1:0] QMAX     = {{(FRAC_BITS+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic [QW-1:0] QMIN_MAG = QMAX + QW'(1);
    localparam logic signed [PW+1:0] MAX_EXT = {{(PW+3-DW){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [PW+1:0] MIN_EXT = {{(PW+3-DW){1'b1}}, {(DW-1){1'b0}}};

    logic [IW-1:0] ro_reg [N];
    logic [IW-1:0] co_reg [N];
    logic [IW-1:0] mr_reg [N];
    logic [IW-1:0] mc_reg [N];
    logic [CW-1:0] cnt_reg;
    logic [IW-1:0] lr_reg, lc_reg;
    logic          sing_reg;
    logic [DW-1:0] best_reg;
    logic [IW-1:0] pr_reg, pc_reg;
    logic [DW-1:0] piv_reg, m_reg, x_reg, a_reg;
    logic          num_neg_reg, num_zero_reg, pneg_reg;
    logic [PW-1:0] prod_reg;
    logic          ovalid_reg;
    logic [IW-1:0] orow_reg, ocol_reg, orp_reg, ocp_reg;
    logic [DW-1:0] olow_reg, oup_reg;
    logic          osing_reg, olast_reg;

    logic          accept, load_wr;
    logic [AW-1:0] w_addr, l_addr, ld_addr;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [DW-1:0] w_wdata, w_rdata, l_rdata;
    logic [DW-1:0] w_mag, piv_mag, m_mag, x_mag;
    logic          div_done;
    logic [QW-1:0] div_quo, q_mag, q_neg;
    logic [DW-1:0] m_val, upd_val;
    logic signed [PW+1:0] a_ext, p_ext, sum;

    assign accept  = cmd.in_ready && in_valid;
    assign load_wr = accept && (cnt_reg < CW'(CELLS));
    assign w_addr  = AW'(int'(mr_reg[row]) * N + int'(mc_reg[col]));
    assign ld_addr = AW'(int'(mr_reg[lr_reg]) * N + int'(mc_reg[lc_reg]));
    assign l_addr  = AW'(int'(ro_reg[row]) * N + int'(col));

    assign w_mag   = w_rdata[DW-1] ? -w_rdata : w_rdata;
    assign piv_mag = piv_reg[DW-1] ? -piv_reg : piv_reg;
    assign m_mag   = m_reg[DW-1] ? -m_reg : m_reg;
    assign x_mag   = x_reg[DW-1] ? -x_reg : x_reg;

    // quotient magnitude, saturated to the signed range
    assign q_mag = num_zero_reg ? '0 : div_quo;
    assign q_neg = QW'(0) - q_mag;
    always_comb
    begin
        if (!num_neg_reg)
        begin
            m_val = (q_mag > QMAX) ? MAXV : q_mag[DW-1:0];
        end
        else
        begin
            m_val = (q_mag > QMIN_MAG) ? MINV : q_neg[DW-1:0];
        end
    end

    // a - m*x >> FRAC_BITS, saturated
    assign a_ext = {{(PW+2-DW){a_reg[DW-1]}}, a_reg};
    assign p_ext = {2'b00, prod_reg >> FRAC_BITS};
    assign sum   = pneg_reg ? a_ext + p_ext : a_ext - p_ext;
    always_comb
    begin
        if (sum > MAX_EXT)
        begin
            upd_val = MAXV;
        end
        else if (sum < MIN_EXT)
        begin
            upd_val = MINV;
        end
        else
        begin
            upd_val = sum[DW-1:0];
        end
    end

    // clear the eliminated entry below the pivot while its multiplier is stored
    assign w_we    = load_wr || cmd.upd_wr || cmd.lm_wr;
    assign w_waddr = load_wr ? ld_addr : w_addr;
    assign w_wdata = load_wr ? in_data : (cmd.upd_wr ? upd_val : '0);

    lufp_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_work (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .raddr (w_addr),
        .rdata (w_rdata)
    );

    lufp_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_lower (
        .clk   (clk),
        .we    (cmd.lm_wr),
        .waddr (l_addr),
        .wdata (m_val),
        .raddr (l_addr),
        .rdata (l_rdata)
    );

    lufp_div #(.DW(DW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.num_cap),
        .num   (w_mag),
        .den   (piv_mag),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                ro_reg[i] <= IW'(i);
                co_reg[i] <= IW'(i);
                mr_reg[i] <= IW'(i);
                mc_reg[i] <= IW'(i);
            end
            cnt_reg    <= '0;
            lr_reg     <= '0;
            lc_reg     <= '0;
            sing_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                for (int i = 0; i < N; i++)
                begin
                    ro_reg[i] <= IW'(i);
                    co_reg[i] <= IW'(i);
                end
                cnt_reg  <= '0;
                lr_reg   <= '0;
                lc_reg   <= '0;
                sing_reg <= 1'b0;
            end
            else
            begin
                if (load_wr)
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                    if (lc_reg == IW'(N - 1))
                    begin
                        lc_reg <= '0;
                        lr_reg <= lr_reg + IW'(1);
                    end
                    else
                    begin
                        lc_reg <= lc_reg + IW'(1);
                    end
                end
                if (cmd.swap)
                begin
                    for (int i = 0; i < N; i++)
                    begin
                        if (IW'(i) == k)
                        begin
                            ro_reg[i] <= ro_reg[pr_reg];
                            mr_reg[i] <= mr_reg[pr_reg];
                        end
                        else if (IW'(i) == pr_reg)
                        begin
                            ro_reg[i] <= ro_reg[k];
                            mr_reg[i] <= mr_reg[k];
                        end
                        if (IW'(i) == k)
                        begin
                            co_reg[i] <= co_reg[pc_reg];
                            mc_reg[i] <= mc_reg[pc_reg];
                        end
                        else if (IW'(i) == pc_reg)
                        begin
                            co_reg[i] <= co_reg[k];
                            mc_reg[i] <= mc_reg[k];
                        end
                    end
                end
                if (cmd.piv_cap && (w_rdata == '0))
                begin
                    sing_reg <= 1'b1;
                end
            end
            if (cmd.out_load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (ovalid_reg && out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.srch_cmp && (cmd.srch_first || (w_mag > best_reg)))
        begin
            best_reg <= w_mag;
            pr_reg   <= row;
            pc_reg   <= col;
        end
        if (cmd.piv_cap)
        begin
            piv_reg <= w_rdata;
        end
        if (cmd.num_cap)
        begin
            num_neg_reg  <= w_rdata[DW-1] ^ piv_reg[DW-1];
            num_zero_reg <= (w_rdata == '0);
        end
        if (cmd.lm_wr)
        begin
            m_reg <= m_val;
        end
        if (cmd.x_cap)
        begin
            x_reg <= w_rdata;
        end
        if (cmd.a_cap)
        begin
            a_reg <= w_rdata;
        end
        if (cmd.mul)
        begin
            prod_reg <= PW'(m_mag) * PW'(x_mag);
            pneg_reg <= m_reg[DW-1] ^ x_reg[DW-1];
        end
        if (cmd.out_load)
        begin
            orow_reg  <= row;
            ocol_reg  <= col;
            olow_reg  <= (col < row) ? l_rdata : ((col == row) ? ONE : '0);
            oup_reg   <= (col >= row) ? w_rdata : '0;
            orp_reg   <= ro_reg[row];
            ocp_reg   <= co_reg[col];
            osing_reg <= sing_reg;
            olast_reg <= (row == IW'(N - 1)) && (col == IW'(N - 1));
        end
    end

    assign st.load_last = accept && in_last;
    assign st.div_done  = div_done;
    assign st.out_taken = ovalid_reg && out_ready;

    assign out_valid    = ovalid_reg;
    assign out_row      = orow_reg;
    assign out_col      = ocol_reg;
    assign out_lower    = olow_reg;
    assign out_upper    = oup_reg;
    assign out_row_perm = orp_reg;
    assign out_col_perm = ocp_reg;
    assign out_singular = osing_reg;
    assign out_last     = olast_reg;

endmodule

### sv/lufp_ctrl.sv
// Sequencer: load, pivot search, swap, elimination, result emission.
module lufp_ctrl import lufp_pkg::*; #(
    parameter int N = MATRIX_SIZE_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lufp_status_t         st,
    output lufp_cmd_t            cmd,
    output logic [$clog2(N)-1:0] row,
    output logic [$clog2(N)-1:0] col,
    output logic [$clog2(N)-1:0] k
);

    localparam int IW = $clog2(N);
    localparam logic [IW-1:0] LAST = IW'(N - 1);

    lufp_state_t   state_reg, state_next;
    logic [IW-1:0] k_reg, k_next;
    logic [IW-1:0] r_reg, r_next;
    logic [IW-1:0] c_reg, c_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            k_reg     <= '0;
            r_reg     <= '0;
            c_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        cmd        = '0;
        row        = r_reg;
        col        = c_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                cmd.in_ready = 1'b1;
                if (st.load_last)
                begin
                    k_next     = '0;
                    r_next     = '0;
                    c_next     = '0;
                    state_next = ST_S_RD;
                end
            end
            ST_S_RD:
            begin
                state_next = ST_S_CMP;
            end
            ST_S_CMP:
            begin
                cmd.srch_cmp   = 1'b1;
                cmd.srch_first = (r_reg == k_reg) && (c_reg == k_reg);
                if (c_reg == LAST)
                begin
                    c_next = k_reg;
                    if (r_reg == LAST)
                    begin
                        state_next = ST_SWAP;
                    end
                    else
                    begin
                        r_next     = r_reg + IW'(1);
                        state_next = ST_S_RD;
                    end
                end
                else
                begin
                    c_next     = c_reg + IW'(1);
                    state_next = ST_S_RD;
                end
            end
            ST_SWAP:
            begin
                cmd.swap   = 1'b1;
                state_next = ST_P_RD;
            end
            ST_P_RD:
            begin
                row        = k_reg;
                col        = k_reg;
                state_next = ST_P_CAP;
            end
            ST_P_CAP:
            begin
                row         = k_reg;
                col         = k_reg;
                cmd.piv_cap = 1'b1;
                if (k_reg == LAST)
                begin
                    r_next     = '0;
                    c_next     = '0;
                    state_next = ST_O_RD;
                end
                else
                begin
                    r_next     = k_reg + IW'(1);
                    state_next = ST_N_RD;
                end
            end
            ST_N_RD:
            begin
                col        = k_reg;
                state_next = ST_N_CAP;
            end
            ST_N_CAP:
            begin
                col         = k_reg;
                cmd.num_cap = 1'b1;
                state_next  = ST_DIV;
            end
            ST_DIV:
            begin
                col = k_reg;
                if (st.div_done)
                begin
                    cmd.lm_wr  = 1'b1;
                    c_next     = k_reg + IW'(1);
                    state_next = ST_X_RD;
                end
            end
            ST_X_RD:
            begin
                row        = k_reg;
                state_next = ST_X_CAP;
            end
            ST_X_CAP:
            begin
                row        = k_reg;
                cmd.x_cap  = 1'b1;
                state_next = ST_A_RD;
            end
            ST_A_RD:
            begin
                state_next = ST_A_CAP;
            end
            ST_A_CAP:
            begin
                cmd.a_cap  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.upd_wr = 1'b1;
                if (c_reg != LAST)
                begin
                    c_next     = c_reg + IW'(1);
                    state_next = ST_X_RD;
                end
                else if (r_reg != LAST)
                begin
                    r_next     = r_reg + IW'(1);
                    state_next = ST_N_RD;
                end
                else
                begin
                    // next column: search the trailing submatrix
                    k_next     = k_reg + IW'(1);
                    r_next     = k_reg + IW'(1);
                    c_next     = k_reg + IW'(1);
                    state_next = ST_S_RD;
                end
            end
            ST_O_RD:
            begin
                state_next = ST_O_CAP;
            end
            ST_O_CAP:
            begin
                cmd.out_load = 1'b1;
                state_next   = ST_O_WAIT;
            end
            ST_O_WAIT:
            begin
                if (st.out_taken)
                begin
                    if (c_reg != LAST)
                    begin
                        c_next     = c_reg + IW'(1);
                        state_next = ST_O_RD;
                    end
                    else if (r_reg != LAST)
                    begin
                        c_next     = '0;
                        r_next     = r_reg + IW'(1);
                        state_next = ST_O_RD;
                    end
                    else
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign k = k_reg;

endmodule

### sv/lu_full_pivot_decomposer.sv
// Loading takes one entry per cycle. After the entry marked last the matrix is
// decomposed, then its results follow one at a time, 16 for a 4x4 matrix.
// The bit-serial divider and the single read port of the work store set the run
// time; one matrix is in flight at a time.
// Reset: asynchronous, active low; returns to loading with identity permutations.
module lu_full_pivot_decomposer import lufp_pkg::*; #(
    parameter int MATRIX_SIZE = MATRIX_SIZE_DEF,
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    // entry transfer: tdata = entry_value; tlast = last_entry
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [((DATA_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
    input  logic                              s_axis_tlast,
    // result transfer: tdata = row_index, col_index, lower_value, upper_value,
    // row_perm, col_perm (from bit 0 up, zero padded); tuser = singular;
    // tlast = last_result
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [((4*$clog2(MATRIX_SIZE)+2*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    output logic [0:0]                        m_axis_tuser,
    output logic                              m_axis_tlast
);

    localparam int IW  = $clog2(MATRIX_SIZE);
    localparam int OW  = 4 * IW + 2 * DATA_WIDTH;
    localparam int OTW = ((OW + 7) / 8) * 8;

    lufp_cmd_t       cmd;
    lufp_status_t    st;
    logic [IW-1:0]   row, col, k;
    logic [IW-1:0]   o_row, o_col, o_rp, o_cp;
    logic [DATA_WIDTH-1:0] o_low, o_up;
    logic            o_sing;

    // sequencer: owns the loop counters over pivot column, row and column
    lufp_ctrl #(.N(MATRIX_SIZE)) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd),
        .row   (row),
        .col   (col),
        .k     (k)
    );

    // datapath: stores, pivot search, divide, multiply-subtract, output register
    lufp_dp #(.N(MATRIX_SIZE), .DW(DATA_WIDTH)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .row          (row),
        .col          (col),
        .k            (k),
        .in_valid     (s_axis_tvalid),
        .in_data      (s_axis_tdata[DATA_WIDTH-1:0]),
        .in_last      (s_axis_tlast),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_row      (o_row),
        .out_col      (o_col),
        .out_lower    (o_low),
        .out_upper    (o_up),
        .out_row_perm (o_rp),
        .out_col_perm (o_cp),
        .out_singular (o_sing),
        .out_last     (m_axis_tlast)
    );

    // accept entries only while loading
    assign s_axis_tready = cmd.in_ready;
    assign m_axis_tdata  = OTW'({o_cp, o_rp, o_up, o_low, o_col, o_row});
    assign m_axis_tuser  = o_sing;

`include "lu_full_pivot_decomposer_assert.svh"

    // no load while a result waits
    `LUFP_ASSERT_NOW(a_no_load_during_emit, m_axis_tvalid, !s_axis_tready)
    // the final result transfer returns the block to loading
    `LUFP_ASSERT_NEXT(a_ready_after_run, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready)
    // the marked entry closes the load phase
    `LUFP_ASSERT_NEXT(a_busy_after_last, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)

endmodule

### test/lu_result_checker.sv
module lu_result_checker import lufp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata,
    input  logic [0:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          pending
);
    localparam int N = 4;
    localparam int CELLS = N * N;
    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;

    typedef struct packed {
        logic [1:0]  row_index;
        logic [1:0]  col_index;
        logic [31:0] lower_value;
        logic [31:0] upper_value;
        logic [1:0]  row_perm;
        logic [1:0]  col_perm;
        logic        singular;
        logic        last_result;
    } lu_elem_t;

    longint   work[CELLS];
    longint   lower[CELLS];
    int       rorder[N];
    int       corder[N];
    int       loaded;
    bit       zero_piv;
    lu_elem_t lu_expected[$];

    function automatic longint unsigned mag_of(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic longint clamp_mag(bit neg, longint unsigned m);
        if (!neg)
            return m > longint'(VMAX) ? VMAX : longint'(m);
        if (m > longint'(VMAX) + 1)
            return VMIN;
        return -longint'(m);
    endfunction

    function automatic longint multiplier(longint a, longint p);
        bit neg;
        longint unsigned ua, up;
        neg = (a < 0) != (p < 0);
        ua = mag_of(a);
        up = mag_of(p);
        if (up == 0)
            return ua == 0 ? 64'sd0 : clamp_mag(neg, 64'hFFFF_FFFF_FFFF_FFFF);
        return clamp_mag(neg, (ua << FRAC_BITS) / up);
    endfunction

    function automatic longint reduce(longint a, longint m, longint x);
        longint unsigned um, ux, prod;
        longint r;
        um = mag_of(m);
        ux = mag_of(x);
        prod = um * (ux >> FRAC_BITS) + ((um * (ux & 64'hFFFF)) >> FRAC_BITS);
        r = ((m < 0) != (x < 0)) ? a + longint'(prod) : a - longint'(prod);
        if (r > VMAX) r = VMAX;
        if (r < VMIN) r = VMIN;
        return r;
    endfunction

    task automatic clear_frame();
        for (int i = 0; i < CELLS; i++)
            lower[i] = (i / N == i % N) ? 64'sd65536 : 64'sd0;
        for (int i = 0; i < N; i++)
        begin
            rorder[i] = i;
            corder[i] = i;
        end
        loaded = 0;
        zero_piv = 0;
    endtask

    // Full-pivot elimination on the held matrix, then queue all 16 elements.
    task automatic decompose_frame();
        int pr, pc, t;
        longint v, m;
        longint unsigned best;
        lu_elem_t e;
        for (int k = 0; k < N; k++)
        begin
            pr = k;
            pc = k;
            best = mag_of(work[k*N+k]);
            for (int r = k; r < N; r++)
                for (int c = k; c < N; c++)
                    if (mag_of(work[r*N+c]) > best)
                    begin
                        best = mag_of(work[r*N+c]);
                        pr = r;
                        pc = c;
                    end
            for (int c = 0; c < N; c++)
            begin
                v = work[k*N+c]; work[k*N+c] = work[pr*N+c]; work[pr*N+c] = v;
            end
            for (int c = 0; c < k; c++)
            begin
                v = lower[k*N+c]; lower[k*N+c] = lower[pr*N+c]; lower[pr*N+c] = v;
            end
            t = rorder[k]; rorder[k] = rorder[pr]; rorder[pr] = t;
            for (int r = 0; r < N; r++)
            begin
                v = work[r*N+k]; work[r*N+k] = work[r*N+pc]; work[r*N+pc] = v;
            end
            t = corder[k]; corder[k] = corder[pc]; corder[pc] = t;
            v = work[k*N+k];
            if (v == 0)
                zero_piv = 1;
            for (int r = k + 1; r < N; r++)
            begin
                m = multiplier(work[r*N+k], v);
                lower[r*N+k] = m;
                work[r*N+k] = 0;
                for (int c = k + 1; c < N; c++)
                    work[r*N+c] = reduce(work[r*N+c], m, work[k*N+c]);
            end
        end
        for (int n = 0; n < CELLS; n++)
        begin
            e.row_index   = n / N;
            e.col_index   = n % N;
            e.lower_value = lower[n][31:0];
            e.upper_value = (n % N >= n / N) ? work[n][31:0] : 32'd0;
            e.row_perm    = rorder[n / N];
            e.col_perm    = corder[n % N];
            e.singular    = zero_piv;
            e.last_result = (n == CELLS - 1);
            lu_expected.push_back(e);
        end
        clear_frame();
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
        for (int i = 0; i < CELLS; i++)
            work[i] = 0;
        clear_frame();
    end

    always @(posedge clk)
    begin
        lu_elem_t want, got;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (loaded < CELLS)
                begin
                    work[loaded] = longint'($signed(s_axis_tdata));
                    loaded++;
                end
                if (s_axis_tlast)
                    decompose_frame();
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.row_index   = m_axis_tdata[1:0];
                got.col_index   = m_axis_tdata[3:2];
                got.lower_value = m_axis_tdata[35:4];
                got.upper_value = m_axis_tdata[67:36];
                got.row_perm    = m_axis_tdata[69:68];
                got.col_perm    = m_axis_tdata[71:70];
                got.singular    = m_axis_tuser[0];
                got.last_result = m_axis_tlast;
                if (lu_expected.size() == 0)
                begin
                    $error("unexpected result transfer, tdata %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = lu_expected.pop_front();
                    if (got.row_index != want.row_index)
                    begin
                        $error("row_index exp %0d got %0d", want.row_index, got.row_index);
                        fail_count++;
                    end
                    if (got.col_index != want.col_index)
                    begin
                        $error("col_index exp %0d got %0d", want.col_index, got.col_index);
                        fail_count++;
                    end
                    if (got.lower_value != want.lower_value)
                    begin
                        $error("lower_value exp %h got %h", want.lower_value, got.lower_value);
                        fail_count++;
                    end
                    if (got.upper_value != want.upper_value)
                    begin
                        $error("upper_value exp %h got %h", want.upper_value, got.upper_value);
                        fail_count++;
                    end
                    if (got.row_perm != want.row_perm)
                    begin
                        $error("row_perm exp %0d got %0d", want.row_perm, got.row_perm);
                        fail_count++;
                    end
                    if (got.col_perm != want.col_perm)
                    begin
                        $error("col_perm exp %0d got %0d", want.col_perm, got.col_perm);
                        fail_count++;
                    end
                    if (got.singular != want.singular)
                    begin
                        $error("singular exp %0d got %0d", want.singular, got.singular);
                        fail_count++;
                    end
                    if (got.last_result != want.last_result)
                    begin
                        $error("last_result exp %0d got %0d", want.last_result,
                               got.last_result);
                        fail_count++;
                    end
                end
            end
        end
        pending = lu_expected.size();
    end
endmodule

### test/testbench.sv
module testbench;
    // Generous: a correct run of ~27 matrices stays well inside this limit.
    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // entry_value
    logic        s_axis_tlast;   // last_entry
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // row_index, col_index, lower_value, upper_value, row_perm, col_perm
    logic [71:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;   // singular
    logic        m_axis_tlast;   // last_result

    int fail_count;
    int pending;
    int cycles;
    int entries_sent;
    int frames_sent;
    bit quiet;       // no idling on either side while set
    int rx_taken;
    int rx_seen;
    int rx_wait;

    lu_full_pivot_decomposer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    lu_result_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
        clk = 0;
    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // Abort a hung run.
    initial
        cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Count result transfers at the rising edge; the falling-edge block
    // draws a fresh stall for each one it has not yet seen.
    initial
    begin
        rx_taken = 0;
        rx_seen = 0;
        rx_wait = 0;
    end
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            rx_taken++;
    always @(negedge clk)
    begin
        if (rx_seen != rx_taken)
        begin
            rx_seen = rx_taken;
            rx_wait = quiet ? 0 : $urandom_range(0, 11);
        end
        if (rx_wait > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_wait--;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Call at a falling edge; returns at the falling edge after the transfer.
    task automatic send_entry(input logic [31:0] value, input logic last);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        entries_sent++;
        if (last)
            frames_sent++;
        @(negedge clk);
    endtask

    // Draw one entry of a given flavor of matrix.
    function automatic logic [31:0] pick_entry(input int flavor);
        logic [31:0] v;
        case (flavor)
            0: v = $urandom();
            1: v = $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
            2: v = ($urandom_range(0, 3) == 0) ? $urandom() : 32'd0;
            3:
            begin
                case ($urandom_range(0, 4))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h8000_0001;
                    3: v = 32'd0;
                    default: v = $urandom();
                endcase
            end
            default: v = $urandom_range(0, 1) ? 32'h0003_0000 : 32'hFFFD_0000;
        endcase
        return v;
    endfunction

    task automatic send_frame(input int flavor, input int count);
        for (int i = 0; i < count; i++)
            send_entry(pick_entry(flavor), i == count - 1);
    endtask

    initial
    begin
        int flavor, count;
        s_axis_tvalid = 0;
        s_axis_tdata  = 0;
        s_axis_tlast  = 0;
        m_axis_tready = 0;
        entries_sent  = 0;
        frames_sent   = 0;
        quiet = 0;
        rst_n = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: a full matrix of extreme values, most negative first.
        send_entry(32'h8000_0000, 0);
        send_entry(32'h7FFF_FFFF, 0);
        send_entry(32'h0000_0000, 0);
        send_entry(32'hFFFF_FFFF, 0);
        for (int i = 4; i < 15; i++)
            send_entry(pick_entry(3), 0);
        send_entry(32'h0001_0000, 1);
        // Short frame: rewrite only the first row, the rest stays eliminated.
        send_entry(32'h0000_0000, 0);
        send_entry(32'h0000_0000, 0);
        send_entry(32'h0000_0000, 0);
        send_entry(32'h0000_0000, 1);
        wait (pending == 0);
        @(negedge clk);

        // Random frames, mostly well formed, some short or overlong.
        while (entries_sent < 420)
        begin
            flavor = $urandom_range(0, 4);
            case ($urandom_range(0, 9))
                0: count = $urandom_range(1, 15);
                1: count = $urandom_range(17, 20);
                default: count = 16;
            endcase
            quiet = ($urandom_range(0, 4) == 0);
            // Hold off now and then until every result of the last frame is in.
            if ($urandom_range(0, 3) == 0)
            begin
                wait (pending == 0);
                @(negedge clk);
            end
            send_frame(flavor, count);
        end
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (600) @(posedge clk);

        $display("Sent %0d entries in %0d frames: random, small, sparse, extreme and tied",
                 entries_sent, frames_sent);
        $display("matrices, with short and overlong frames and random idling on both sides.");
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
